@@ src/gost_block_cipher_defines.svh @@
// Assertion macros shared by the checker of the block cipher.
// Needs a clock named i_clk and an active low reset named i_rst_n in scope.
`ifndef GOST_BLOCK_CIPHER_DEFINES_SVH
`define GOST_BLOCK_CIPHER_DEFINES_SVH

// Property that is checked only while the block is out of reset.
`define GOST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Property that is checked during reset as well.
`define GOST_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ src/gost_pkg.sv @@
// Shared types, constants and round functions of the GOST block cipher.
// No dependencies; every other file but the macro header refers to it by scoped names.
package gost_pkg;

    localparam int BLOCK_W = 64;
    localparam int WORD_W  = 32;
    localparam int ROUNDS  = 32;
    localparam int NKEYS   = 8;
    localparam int KIDX_W  = 3;
    localparam int RND_W   = 5;
    localparam int ROT_L   = 11;
    localparam int ROT_R   = 21;
    localparam logic [3:0] NIB_MASK = 4'hF;

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [BLOCK_W-1:0] t_block;
    typedef logic [KIDX_W-1:0]  t_key_idx;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_KEY_01  = 3'd0,
        REG_KEY_23  = 3'd1,
        REG_KEY_45  = 3'd2,
        REG_KEY_67  = 3'd3,
        REG_DECRYPT = 3'd4
    } t_reg_idx;

    // Key material and mode as seen by the round cells.
    typedef struct packed {
        logic [NKEYS-1:0][WORD_W-1:0] words;
        logic                         decrypt;
    } t_key_state;

    // Row 0 serves the top nibble, row 7 the bottom nibble.
    localparam logic [3:0] SBOX [8][16] = '{
        '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
          4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7},
        '{4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
          4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10},
        '{4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
          4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8},
        '{4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
          4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15},
        '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
          4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9},
        '{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
          4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11},
        '{4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
          4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1},
        '{4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
          4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7}
    };

    localparam logic [KIDX_W-1:0] KEY_ORDER [ROUNDS] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
        3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0
    };

    // Key word used by a given round position; decryption walks the order backward.
    function automatic t_key_idx key_index(input logic [RND_W-1:0] rnd, input logic decrypt);
        logic [RND_W-1:0] pos;
        pos = decrypt ? ~rnd : rnd;
        return KEY_ORDER[pos];
    endfunction

    function automatic t_word substitute(input t_word x);
        t_word y;
        y = '0;
        for (int n = 0; n < 8; n++) begin
            y[WORD_W-1-4*n -: 4] = SBOX[n][x[WORD_W-1-4*n -: 4] & NIB_MASK];
        end
        return y;
    endfunction

    function automatic t_word round_fn(input t_word r, input t_word k);
        t_word t;
        t = substitute(r + k);
        return (t << ROT_L) | (t >> ROT_R);
    endfunction

endpackage

@@ src/gost_ifs.sv @@
// Handshake interfaces of the GOST block cipher: data blocks and register writes.
// Depends on gost_pkg.
interface gost_blk_if;
    logic                 valid;
    logic                 ready;
    gost_pkg::t_block     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gost_cfg_if;
    logic                 valid;
    logic                 ready;
    logic [2:0]           index;
    gost_pkg::t_block     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/gost_key_store.sv @@
// Configuration registers of the cipher: eight key words and the mode bit.
// Depends on gost_pkg.
module gost_key_store (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [2:0]            i_wr_index,
    input  gost_pkg::t_block      i_wr_data,
    output gost_pkg::t_key_state  o_keys
);

    gost_pkg::t_key_state r_keys;
    gost_pkg::t_key_state n_keys;

    always_comb begin
        n_keys = r_keys;
        if (i_wr_en) begin
            case (i_wr_index)
                gost_pkg::REG_KEY_01: begin
                    n_keys.words[0] = i_wr_data[63:32];
                    n_keys.words[1] = i_wr_data[31:0];
                end
                gost_pkg::REG_KEY_23: begin
                    n_keys.words[2] = i_wr_data[63:32];
                    n_keys.words[3] = i_wr_data[31:0];
                end
                gost_pkg::REG_KEY_45: begin
                    n_keys.words[4] = i_wr_data[63:32];
                    n_keys.words[5] = i_wr_data[31:0];
                end
                gost_pkg::REG_KEY_67: begin
                    n_keys.words[6] = i_wr_data[63:32];
                    n_keys.words[7] = i_wr_data[31:0];
                end
                gost_pkg::REG_DECRYPT: begin
                    n_keys.decrypt = i_wr_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys <= '0;
        end else begin
            r_keys <= n_keys;
        end
    end

    assign o_keys = r_keys;

endmodule

@@ src/gost_round_cell.sv @@
// One Feistel round of the cipher with its pipeline register.
// Depends on gost_pkg.
module gost_round_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic               i_valid,
    input  gost_pkg::t_word    i_r,
    input  gost_pkg::t_word    i_l,
    input  gost_pkg::t_word    i_key,
    output logic               o_valid,
    output gost_pkg::t_word    o_r,
    output gost_pkg::t_word    o_l
);

    logic            r_valid;
    gost_pkg::t_word r_r;
    gost_pkg::t_word r_l;
    gost_pkg::t_word n_r;

    assign n_r = gost_pkg::round_fn(i_r, i_key) ^ i_l;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_r <= n_r;
            r_l <= i_r;
        end
    end

    assign o_valid = r_valid;
    assign o_r     = r_r;
    assign o_l     = r_l;

endmodule

@@ src/gost_block_cipher.sv @@
// Top level of the GOST 28147-89 block cipher: a chain of 32 round cells.
// Depends on gost_pkg, gost_ifs, gost_key_store and gost_round_cell.
//
//   port   | direction | carries
//   i_in   | sink      | data: 64-bit block, first byte in bits 63..56
//   o_out  | source    | data: 64-bit result, first byte in bits 63..56
//   i_cfg  | sink      | index 0..3 key word pairs, 4 decrypt mode; data
//
// One block enters per cycle while the chain advances; each block passes through the
// 32 round cell registers in order, the last cell's register being the output register.
// The whole chain holds while a result waits and o_out.ready is low.
// Reset is synchronous and clears the key, the mode and all valid bits.
// Register writes are taken in any cycle.
module gost_block_cipher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gost_blk_if.sink   i_in,
    gost_blk_if.source o_out,
    gost_cfg_if.sink   i_cfg
);

    gost_pkg::t_key_state keys;
    logic                 advance;

    logic            cell_valid [gost_pkg::ROUNDS+1];
    gost_pkg::t_word cell_r     [gost_pkg::ROUNDS+1];
    gost_pkg::t_word cell_l     [gost_pkg::ROUNDS+1];

    assign i_cfg.ready = 1'b1;

    gost_key_store u_keys (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_keys     (keys)
    );

    assign advance = !cell_valid[gost_pkg::ROUNDS] || o_out.ready;

    assign cell_valid[0] = i_in.valid;
    assign cell_r[0]     = i_in.data[63:32];
    assign cell_l[0]     = i_in.data[31:0];

    for (genvar g = 0; g < gost_pkg::ROUNDS; g++) begin : g_round
        gost_pkg::t_key_idx kidx;
        assign kidx = gost_pkg::key_index(gost_pkg::RND_W'(g), keys.decrypt);

        gost_round_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (advance),
            .i_valid   (cell_valid[g]),
            .i_r       (cell_r[g]),
            .i_l       (cell_l[g]),
            .i_key     (keys.words[kidx]),
            .o_valid   (cell_valid[g+1]),
            .o_r       (cell_r[g+1]),
            .o_l       (cell_l[g+1])
        );
    end

    assign i_in.ready  = advance;
    assign o_out.valid = cell_valid[gost_pkg::ROUNDS];
    assign o_out.data  = {cell_l[gost_pkg::ROUNDS], cell_r[gost_pkg::ROUNDS]};

endmodule

@@ src/gost_block_cipher_checker.sv @@
// Port-level checker of the GOST block cipher and its bind to the top level.
// Depends on gost_pkg and gost_block_cipher_defines.svh.
`include "gost_block_cipher_defines.svh"

module gost_block_cipher_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  gost_pkg::t_block  i_out_data,
    input  logic              i_cfg_ready
);

    // A waiting result must not change or vanish.
    `GOST_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data), "output changed while stalled")

    // The chain takes a block exactly when the output stage can move.
    `GOST_ASSERT(a_in_ready, i_in_ready == (!i_out_valid || i_out_ready), "input ready does not follow output stall")

    // No result is shown right after reset.
    `GOST_ASSERT_RST(a_reset_empty, !i_rst_n |=> !i_out_valid, "output valid after reset")

    // Register writes are never held off.
    `GOST_ASSERT(a_cfg_ready, i_in_valid || !i_in_valid |-> i_cfg_ready, "config port not ready")

endmodule

bind gost_block_cipher gost_block_cipher_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data),
    .i_cfg_ready (i_cfg.ready)
);
